// File: src/psa_pkg.sv
// Shared types, widths and constants for the polygon solid angle block.
// Holds the microcode of the multiply-accumulate sequencer and the CORDIC angle table.
// Depends on nothing; used by psa_isqrt and polygon_solid_angle.
package psa_pkg;

  // Datapath widths, fixed by the Q9.16 difference format.
  localparam int unsigned DV_W   = 25;          // vertex minus point
  localparam int unsigned SQ_W   = 2 * DV_W;    // squared length
  localparam int unsigned RT_W   = SQ_W / 2;    // length
  localparam int unsigned WD_W   = 2 * DV_W + 1; // cross, dot and length products
  localparam int unsigned OP_W   = DV_W + 2;    // multiplier operand
  localparam int unsigned PR_W   = 2 * OP_W;    // multiplier product
  localparam int unsigned ACC_W  = 80;          // numerator and denominator
  localparam int unsigned NRM_W  = 40;          // significant bits fed to the CORDIC
  localparam int unsigned CX_W   = 44;          // CORDIC x and y
  localparam int unsigned Z_W    = 28;          // CORDIC angle, Q.24
  localparam int unsigned HI_SH  = DV_W;        // weight of the upper operand half

  localparam int unsigned CORDIC_STEPS = 25;
  localparam int unsigned NORM_STEPS   = 7;
  localparam int unsigned UCODE_LEN    = 39;
  localparam int unsigned PC_W         = 6;

  localparam logic signed [Z_W-1:0] PI_Q24 = Z_W'(52707179);

  // Operand sources of the shared multiplier.
  typedef enum logic [4:0] {
    SRC_D00, SRC_D01, SRC_D02,
    SRC_D10, SRC_D11, SRC_D12,
    SRC_D20, SRC_D21, SRC_D22,
    SRC_R0, SRC_R1, SRC_R2,
    SRC_CR0, SRC_CR1, SRC_CR2,
    SRC_P12, SRC_P23, SRC_P31,
    SRC_RR
  } src_e;

  // Registers that take the accumulator result.
  typedef enum logic [3:0] {
    DST_NONE, DST_CR0, DST_CR1, DST_CR2,
    DST_P12, DST_P23, DST_P31, DST_RR,
    DST_NUM, DST_DEN
  } dst_e;

  // One microinstruction of the multiply-accumulate sequencer.
  typedef struct packed {
    src_e       a;
    logic       a_hi;   // take the upper half of a wide operand, weighted by HI_SH
    src_e       b;
    logic       clr;    // start a new sum
    logic       sub;    // subtract the product
    dst_e       dst;
    logic       sqrt;   // hand the sum to the square root unit
    logic [1:0] rsel;   // length register that the root goes to
    logic       last;
  } uop_t;

  function automatic uop_t mk(input src_e a, input logic a_hi, input src_e b,
                              input logic clr, input logic sub, input dst_e dst,
                              input logic sqrt, input logic [1:0] rsel,
                              input logic last);
    uop_t u;
    u.a    = a;
    u.a_hi = a_hi;
    u.b    = b;
    u.clr  = clr;
    u.sub  = sub;
    u.dst  = dst;
    u.sqrt = sqrt;
    u.rsel = rsel;
    u.last = last;
    return u;
  endfunction

  // Program for one fan triangle: lengths, cross product, numerator, dot
  // products and denominator.
  function automatic uop_t uop_at(input logic [PC_W-1:0] pc);
    uop_t u;
    unique case (pc)
      6'd0:  u = mk(SRC_D00, 1'b0, SRC_D00, 1'b1, 1'b0, DST_NONE, 1'b0, 2'd0, 1'b0);
      6'd1:  u = mk(SRC_D01, 1'b0, SRC_D01, 1'b0, 1'b0, DST_NONE, 1'b0, 2'd0, 1'b0);
      6'd2:  u = mk(SRC_D02, 1'b0, SRC_D02, 1'b0, 1'b0, DST_NONE, 1'b1, 2'd0, 1'b0);
      6'd3:  u = mk(SRC_D10, 1'b0, SRC_D10, 1'b1, 1'b0, DST_NONE, 1'b0, 2'd0, 1'b0);
      6'd4:  u = mk(SRC_D11, 1'b0, SRC_D11, 1'b0, 1'b0, DST_NONE, 1'b0, 2'd0, 1'b0);
      6'd5:  u = mk(SRC_D12, 1'b0, SRC_D12, 1'b0, 1'b0, DST_NONE, 1'b1, 2'd1, 1'b0);
      6'd6:  u = mk(SRC_D20, 1'b0, SRC_D20, 1'b1, 1'b0, DST_NONE, 1'b0, 2'd0, 1'b0);
      6'd7:  u = mk(SRC_D21, 1'b0, SRC_D21, 1'b0, 1'b0, DST_NONE, 1'b0, 2'd0, 1'b0);
      6'd8:  u = mk(SRC_D22, 1'b0, SRC_D22, 1'b0, 1'b0, DST_NONE, 1'b1, 2'd2, 1'b0);
      6'd9:  u = mk(SRC_D11, 1'b0, SRC_D22, 1'b1, 1'b0, DST_NONE, 1'b0, 2'd0, 1'b0);
      6'd10: u = mk(SRC_D12, 1'b0, SRC_D21, 1'b0, 1'b1, DST_CR0,  1'b0, 2'd0, 1'b0);
      6'd11: u = mk(SRC_D12, 1'b0, SRC_D20, 1'b1, 1'b0, DST_NONE, 1'b0, 2'd0, 1'b0);
      6'd12: u = mk(SRC_D10, 1'b0, SRC_D22, 1'b0, 1'b1, DST_CR1,  1'b0, 2'd0, 1'b0);
      6'd13: u = mk(SRC_D10, 1'b0, SRC_D21, 1'b1, 1'b0, DST_NONE, 1'b0, 2'd0, 1'b0);
      6'd14: u = mk(SRC_D11, 1'b0, SRC_D20, 1'b0, 1'b1, DST_CR2,  1'b0, 2'd0, 1'b0);
      6'd15: u = mk(SRC_CR0, 1'b0, SRC_D00, 1'b1, 1'b0, DST_NONE, 1'b0, 2'd0, 1'b0);
      6'd16: u = mk(SRC_CR0, 1'b1, SRC_D00, 1'b0, 1'b0, DST_NONE, 1'b0, 2'd0, 1'b0);
      6'd17: u = mk(SRC_CR1, 1'b0, SRC_D01, 1'b0, 1'b0, DST_NONE, 1'b0, 2'd0, 1'b0);
      6'd18: u = mk(SRC_CR1, 1'b1, SRC_D01, 1'b0, 1'b0, DST_NONE, 1'b0, 2'd0, 1'b0);
      6'd19: u = mk(SRC_CR2, 1'b0, SRC_D02, 1'b0, 1'b0, DST_NONE, 1'b0, 2'd0, 1'b0);
      6'd20: u = mk(SRC_CR2, 1'b1, SRC_D02, 1'b0, 1'b0, DST_NUM,  1'b0, 2'd0, 1'b0);
      6'd21: u = mk(SRC_D00, 1'b0, SRC_D10, 1'b1, 1'b0, DST_NONE, 1'b0, 2'd0, 1'b0);
      6'd22: u = mk(SRC_D01, 1'b0, SRC_D11, 1'b0, 1'b0, DST_NONE, 1'b0, 2'd0, 1'b0);
      6'd23: u = mk(SRC_D02, 1'b0, SRC_D12, 1'b0, 1'b0, DST_P12,  1'b0, 2'd0, 1'b0);
      6'd24: u = mk(SRC_D10, 1'b0, SRC_D20, 1'b1, 1'b0, DST_NONE, 1'b0, 2'd0, 1'b0);
      6'd25: u = mk(SRC_D11, 1'b0, SRC_D21, 1'b0, 1'b0, DST_NONE, 1'b0, 2'd0, 1'b0);
      6'd26: u = mk(SRC_D12, 1'b0, SRC_D22, 1'b0, 1'b0, DST_P23,  1'b0, 2'd0, 1'b0);
      6'd27: u = mk(SRC_D20, 1'b0, SRC_D00, 1'b1, 1'b0, DST_NONE, 1'b0, 2'd0, 1'b0);
      6'd28: u = mk(SRC_D21, 1'b0, SRC_D01, 1'b0, 1'b0, DST_NONE, 1'b0, 2'd0, 1'b0);
      6'd29: u = mk(SRC_D22, 1'b0, SRC_D02, 1'b0, 1'b0, DST_P31,  1'b0, 2'd0, 1'b0);
      6'd30: u = mk(SRC_R0,  1'b0, SRC_R1,  1'b1, 1'b0, DST_RR,   1'b0, 2'd0, 1'b0);
      6'd31: u = mk(SRC_RR,  1'b0, SRC_R2,  1'b1, 1'b0, DST_NONE, 1'b0, 2'd0, 1'b0);
      6'd32: u = mk(SRC_RR,  1'b1, SRC_R2,  1'b0, 1'b0, DST_NONE, 1'b0, 2'd0, 1'b0);
      6'd33: u = mk(SRC_P12, 1'b0, SRC_R2,  1'b0, 1'b0, DST_NONE, 1'b0, 2'd0, 1'b0);
      6'd34: u = mk(SRC_P12, 1'b1, SRC_R2,  1'b0, 1'b0, DST_NONE, 1'b0, 2'd0, 1'b0);
      6'd35: u = mk(SRC_P23, 1'b0, SRC_R0,  1'b0, 1'b0, DST_NONE, 1'b0, 2'd0, 1'b0);
      6'd36: u = mk(SRC_P23, 1'b1, SRC_R0,  1'b0, 1'b0, DST_NONE, 1'b0, 2'd0, 1'b0);
      6'd37: u = mk(SRC_P31, 1'b0, SRC_R1,  1'b0, 1'b0, DST_NONE, 1'b0, 2'd0, 1'b0);
      6'd38: u = mk(SRC_P31, 1'b1, SRC_R1,  1'b0, 1'b0, DST_DEN,  1'b0, 2'd0, 1'b1);
      default: u = mk(SRC_D00, 1'b0, SRC_D00, 1'b1, 1'b0, DST_NONE, 1'b0, 2'd0, 1'b1);
    endcase
    return u;
  endfunction

  // atan(2^-i) in Q.24, rounded to nearest.
  function automatic logic signed [Z_W-1:0] atan_q24(input logic [4:0] i);
    logic signed [Z_W-1:0] v;
    unique case (i)
      5'd0:  v = Z_W'(13176795);
      5'd1:  v = Z_W'(7778716);
      5'd2:  v = Z_W'(4110060);
      5'd3:  v = Z_W'(2086331);
      5'd4:  v = Z_W'(1047214);
      5'd5:  v = Z_W'(524117);
      5'd6:  v = Z_W'(262123);
      5'd7:  v = Z_W'(131069);
      5'd8:  v = Z_W'(65536);
      5'd9:  v = Z_W'(32768);
      5'd10: v = Z_W'(16384);
      5'd11: v = Z_W'(8192);
      5'd12: v = Z_W'(4096);
      5'd13: v = Z_W'(2048);
      5'd14: v = Z_W'(1024);
      5'd15: v = Z_W'(512);
      5'd16: v = Z_W'(256);
      5'd17: v = Z_W'(128);
      5'd18: v = Z_W'(64);
      5'd19: v = Z_W'(32);
      5'd20: v = Z_W'(16);
      5'd21: v = Z_W'(8);
      5'd22: v = Z_W'(4);
      5'd23: v = Z_W'(2);
      5'd24: v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: src/psa_isqrt.sv
// Bit-serial floor square root, one result bit per cycle.
// Depends on psa_pkg for the radicand and root widths.
module psa_isqrt
  import psa_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [SQ_W-1:0] radicand_i,
  output logic            done_o,
  output logic [RT_W-1:0] root_o
);

  localparam int unsigned REM_W = RT_W + 3;

  logic [SQ_W-1:0]  rad_q;
  logic [REM_W-1:0] rem_q;
  logic [RT_W-1:0]  root_q;
  logic [4:0]       cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [REM_W-1:0] rem_n;
  logic [REM_W-1:0] trial;
  logic             take;

  // Bring down the next two radicand bits and try the next root bit.
  assign rem_n = {1'b0, rem_q[REM_W-4:0], rad_q[SQ_W-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign take  = rem_n >= trial;

  // Control: step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(RT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and root.
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= take ? rem_n - trial : rem_n;
      root_q <= {root_q[RT_W-2:0], take};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// File: src/polygon_solid_angle.sv
// Solid angle of a polygon seen from a point, summed over fan triangles.
// Flow: from the third vertex on, a vertex runs the shared multiply-accumulate program,
// which waits on three bit-serial square roots, then a 7-step normalizer and 25 CORDIC
// steps; the CORDIC is skipped when the numerator is zero. A vertex that needs no triangle
// is taken in S_IDLE alone; a closing vertex then loads the output register in S_DONE.
// One vertex is worked on at a time: the input is not ready while busy.
// Reset: rst_ni is asynchronous, active low; it clears the vertex count and output valid.
module polygon_solid_angle
  import psa_pkg::*;
#(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned ANGLE_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  // tdata: vx, vy, vz, px, py, pz (COORD_BITS each, from bit 0), zero padded
  input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic                              s_axis_tuser,   // is_first
  input  logic                              s_axis_tlast,   // is_last
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: solid_angle (ANGLE_BITS, from bit 0), zero padded
  output logic [((ANGLE_BITS+7)/8)*8-1:0]   m_axis_tdata,
  output logic                              m_axis_tuser,   // too_few_vertices
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready
);

  localparam int unsigned OUT_TW     = ((ANGLE_BITS+7)/8)*8;
  localparam int unsigned DIFF_SHIFT = (COORD_BITS > 24) ? COORD_BITS - 24 : 0;
  localparam int unsigned SW         = (ANGLE_BITS > 29) ? ANGLE_BITS + 1 : 30;
  localparam logic signed [SW-1:0] AMAX =
    {{(SW-ANGLE_BITS+1){1'b0}}, {(ANGLE_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] AMIN =
    {{(SW-ANGLE_BITS+1){1'b1}}, {(ANGLE_BITS-1){1'b0}}};

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DIFF  = 10'b0000000010,
    S_MAC   = 10'b0000000100,
    S_SQRT  = 10'b0000001000,
    S_ABS   = 10'b0000010000,
    S_NORM  = 10'b0000100000,
    S_CSET  = 10'b0001000000,
    S_CORD  = 10'b0010000000,
    S_ACCUM = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // Polygon state.
  logic signed [COORD_BITS-1:0] first_q [3];
  logic signed [COORD_BITS-1:0] prev_q  [3];
  logic signed [COORD_BITS-1:0] cur_q   [3];
  logic signed [COORD_BITS-1:0] pt_q    [3];
  logic signed [COORD_BITS-1:0] in_v    [3];
  logic signed [COORD_BITS-1:0] in_p    [3];
  logic signed [ANGLE_BITS-1:0] sum_q;
  logic [1:0]                   cnt_q;
  logic                         closes_q;

  // Triangle datapath.
  logic signed [DV_W-1:0]  d_q  [9];
  logic [RT_W-1:0]         r_q  [3];
  logic signed [WD_W-1:0]  cr_q [3];
  logic signed [WD_W-1:0]  pp_q [3];
  logic signed [WD_W-1:0]  rr_q;
  logic signed [ACC_W-1:0] acc_q, acc_d, num_q, den_q;
  logic [ACC_W-1:0]        ym_q, xm_q;
  logic                    yneg_q, xneg_q;
  logic signed [CX_W-1:0]  x_q, y_q;
  logic signed [Z_W-1:0]   z_q;
  logic [PC_W-1:0]         pc_q;
  logic [2:0]              ncnt_q;
  logic [4:0]              icnt_q;

  // Result registers.
  logic signed [ANGLE_BITS-1:0] res_angle_q, out_angle_q;
  logic                         res_few_q, out_few_q, out_valid_q;

  uop_t                    uop;
  logic signed [OP_W-1:0]  opa, opb;
  logic signed [PR_W-1:0]  prod;
  logic signed [ACC_W-1:0] term;
  logic                    in_fire, opens, tri_start, out_free;
  logic                    sq_done;
  logic [RT_W-1:0]         sq_root;
  logic [6:0]              nrm_amt;
  logic [ACC_W-1:0]        nrm_or, nrm_mask;
  logic signed [CX_W-1:0]  y_init, x_init;
  logic signed [SW-1:0]    sum_ext;
  logic signed [ANGLE_BITS-1:0] sum_sat;

  // Input unpacking and transaction control.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      in_v[c] = s_axis_tdata[c*COORD_BITS +: COORD_BITS];
      in_p[c] = s_axis_tdata[(c+3)*COORD_BITS +: COORD_BITS];
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign opens         = s_axis_tuser || (cnt_q == 2'd0);
  assign tri_start     = !opens && (cnt_q != 2'd1);
  assign out_free      = !out_valid_q || m_axis_tready;

  // Operand selection for the shared multiplier.
  function automatic logic signed [OP_W-1:0] pick(input src_e s, input logic hi);
    logic signed [WD_W-1:0] w;
    logic signed [OP_W-1:0] v;
    w = '0;
    v = '0;
    unique case (s)
      SRC_D00: v = OP_W'(d_q[0]);
      SRC_D01: v = OP_W'(d_q[1]);
      SRC_D02: v = OP_W'(d_q[2]);
      SRC_D10: v = OP_W'(d_q[3]);
      SRC_D11: v = OP_W'(d_q[4]);
      SRC_D12: v = OP_W'(d_q[5]);
      SRC_D20: v = OP_W'(d_q[6]);
      SRC_D21: v = OP_W'(d_q[7]);
      SRC_D22: v = OP_W'(d_q[8]);
      SRC_R0:  v = OP_W'(signed'({1'b0, r_q[0]}));
      SRC_R1:  v = OP_W'(signed'({1'b0, r_q[1]}));
      SRC_R2:  v = OP_W'(signed'({1'b0, r_q[2]}));
      SRC_CR0: w = cr_q[0];
      SRC_CR1: w = cr_q[1];
      SRC_CR2: w = cr_q[2];
      SRC_P12: w = pp_q[0];
      SRC_P23: w = pp_q[1];
      SRC_P31: w = pp_q[2];
      SRC_RR:  w = rr_q;
      default: v = '0;
    endcase
    if (s == SRC_CR0 || s == SRC_CR1 || s == SRC_CR2 || s == SRC_P12 ||
        s == SRC_P23 || s == SRC_P31 || s == SRC_RR) begin
      v = hi ? OP_W'(signed'(w[WD_W-1:HI_SH]))
             : OP_W'(signed'({1'b0, w[HI_SH-1:0]}));
    end
    return v;
  endfunction

  // Shared multiply-accumulate unit.
  always_comb begin
    uop  = uop_at(pc_q);
    opa  = pick(uop.a, uop.a_hi);
    opb  = pick(uop.b, 1'b0);
    prod = opa * opb;
    term = ACC_W'(prod);
    if (uop.a_hi) begin
      term = term <<< HI_SH;
    end
    acc_d = (uop.clr ? '0 : acc_q) + (uop.sub ? -term : term);
  end

  psa_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_MAC && uop.sqrt),
    .radicand_i (acc_d[SQ_W-1:0]),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  // Normalizer: shift both magnitudes left by 64, 32, ... 1 while the top is clear.
  assign nrm_amt  = 7'd64 >> ncnt_q;
  assign nrm_or   = ym_q | xm_q;
  assign nrm_mask = ~({ACC_W{1'b1}} >> nrm_amt);

  // CORDIC start values with the signs restored.
  always_comb begin
    y_init = CX_W'(signed'({1'b0, ym_q[ACC_W-1 -: NRM_W]}));
    x_init = CX_W'(signed'({1'b0, xm_q[ACC_W-1 -: NRM_W]}));
    if (yneg_q) y_init = -y_init;
    if (xneg_q) x_init = -x_init;
  end

  // Saturating update of the running sum with -2 times the angle.
  always_comb begin
    sum_ext = SW'(sum_q) - (SW'(z_q) <<< 1);
    if (sum_ext > AMAX) begin
      sum_sat = ANGLE_BITS'(AMAX);
    end else if (sum_ext < AMIN) begin
      sum_sat = ANGLE_BITS'(AMIN);
    end else begin
      sum_sat = ANGLE_BITS'(sum_ext);
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (tri_start) state_d = S_DIFF;
          else if (s_axis_tlast) state_d = S_DONE;
        end
      end
      S_DIFF: state_d = S_MAC;
      S_MAC: begin
        if (uop.sqrt) state_d = S_SQRT;
        else if (uop.last) state_d = S_ABS;
      end
      S_SQRT: if (sq_done) state_d = S_MAC;
      S_ABS:  state_d = S_NORM;
      S_NORM: if (ncnt_q == 3'(NORM_STEPS - 1)) state_d = S_CSET;
      S_CSET: state_d = (y_init == '0) ? S_ACCUM : S_CORD;
      S_CORD: if (icnt_q == 5'(CORDIC_STEPS - 1)) state_d = S_ACCUM;
      S_ACCUM: state_d = closes_q ? S_DONE : S_IDLE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pc_q        <= '0;
      ncnt_q      <= '0;
      icnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (opens) cnt_q <= s_axis_tlast ? 2'd0 : 2'd1;
            else if (cnt_q == 2'd1) cnt_q <= s_axis_tlast ? 2'd0 : 2'd2;
            else cnt_q <= 2'd3;
          end
        end
        S_DIFF: pc_q <= '0;
        S_MAC:  if (!uop.sqrt) pc_q <= pc_q + PC_W'(1);
        S_SQRT: if (sq_done) pc_q <= pc_q + PC_W'(1);
        S_ABS:  ncnt_q <= '0;
        S_NORM: ncnt_q <= ncnt_q + 3'd1;
        S_CSET: icnt_q <= '0;
        S_CORD: icnt_q <= icnt_q + 5'd1;
        S_ACCUM: if (closes_q) cnt_q <= 2'd0;
        S_DONE: ;
        default: ;
      endcase
      // Output register: load a finished result, drop it once taken.
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cur_q       <= in_v;
          closes_q    <= s_axis_tlast;
          res_angle_q <= '0;
          res_few_q   <= 1'b1;
          if (opens) begin
            first_q <= in_v;
            pt_q    <= in_p;
            sum_q   <= '0;
          end else if (cnt_q == 2'd1) begin
            prev_q <= in_v;
          end
        end
      end
      S_DIFF: begin
        for (int c = 0; c < 3; c++) begin
          d_q[c]   <= DV_W'(signed'({first_q[c][COORD_BITS-1], first_q[c]} -
                                    {pt_q[c][COORD_BITS-1], pt_q[c]}) >>> DIFF_SHIFT);
          d_q[3+c] <= DV_W'(signed'({prev_q[c][COORD_BITS-1], prev_q[c]} -
                                    {pt_q[c][COORD_BITS-1], pt_q[c]}) >>> DIFF_SHIFT);
          d_q[6+c] <= DV_W'(signed'({cur_q[c][COORD_BITS-1], cur_q[c]} -
                                    {pt_q[c][COORD_BITS-1], pt_q[c]}) >>> DIFF_SHIFT);
        end
      end
      S_MAC: begin
        acc_q <= acc_d;
        unique case (uop.dst)
          DST_CR0: cr_q[0] <= WD_W'(acc_d);
          DST_CR1: cr_q[1] <= WD_W'(acc_d);
          DST_CR2: cr_q[2] <= WD_W'(acc_d);
          DST_P12: pp_q[0] <= WD_W'(acc_d);
          DST_P23: pp_q[1] <= WD_W'(acc_d);
          DST_P31: pp_q[2] <= WD_W'(acc_d);
          DST_RR:  rr_q    <= WD_W'(acc_d);
          DST_NUM: num_q   <= acc_d;
          DST_DEN: den_q   <= acc_d;
          DST_NONE: ;
          default: ;
        endcase
      end
      S_SQRT: if (sq_done) r_q[uop.rsel] <= sq_root;
      S_ABS: begin
        yneg_q <= num_q[ACC_W-1];
        xneg_q <= den_q[ACC_W-1];
        ym_q   <= num_q[ACC_W-1] ? unsigned'(-num_q) : unsigned'(num_q);
        xm_q   <= den_q[ACC_W-1] ? unsigned'(-den_q) : unsigned'(den_q);
      end
      S_NORM: begin
        if ((nrm_or & nrm_mask) == '0) begin
          ym_q <= ym_q << nrm_amt;
          xm_q <= xm_q << nrm_amt;
        end
      end
      S_CSET: begin
        // Zero numerator gives 0 or pi; a negative x starts from plus or minus pi.
        if (y_init == '0) begin
          z_q <= (x_init < 0) ? PI_Q24 : '0;
        end else if (x_init < 0) begin
          z_q <= (y_init > 0) ? PI_Q24 : -PI_Q24;
          x_q <= -x_init;
          y_q <= -y_init;
        end else begin
          z_q <= '0;
          x_q <= x_init;
          y_q <= y_init;
        end
      end
      S_CORD: begin
        if (y_q > 0) begin
          x_q <= x_q + (y_q >>> icnt_q);
          y_q <= y_q - (x_q >>> icnt_q);
          z_q <= z_q + atan_q24(icnt_q);
        end else begin
          x_q <= x_q - (y_q >>> icnt_q);
          y_q <= y_q + (x_q >>> icnt_q);
          z_q <= z_q - atan_q24(icnt_q);
        end
      end
      S_ACCUM: begin
        sum_q  <= sum_sat;
        prev_q <= cur_q;
        if (closes_q) begin
          res_angle_q <= sum_sat;
          res_few_q   <= 1'b0;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_angle_q <= res_angle_q;
          out_few_q   <= res_few_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tdata  = OUT_TW'(unsigned'(out_angle_q));
  assign m_axis_tuser  = out_few_q;
  assign m_axis_tvalid = out_valid_q;

`ifndef SYNTH
  // The square root unit only reports while the sequencer waits for it.
  a_sqrt_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> state_q == S_SQRT)
    else $error("square root finished outside its wait state");

  // The wait state always sits on an instruction that requested a root.
  a_sqrt_uop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SQRT |-> uop.sqrt)
    else $error("waiting for a root on an instruction without one");

  // A triangle is only worked on with three vertices held.
  a_tri_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MAC |-> cnt_q == 2'd3)
    else $error("triangle program running without three vertices");

  // A short polygon reports a zero angle.
  a_few_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> out_angle_q == '0)
    else $error("short polygon with a nonzero angle");
`endif

endmodule

// File: tb/sv/tb_polygon_solid_angle.sv
// Self-checking testbench for polygon_solid_angle: vertices stream in, one solid angle per polygon.
// A bit-exact fan-triangle predictor checks every result, while both sides idle at random.
// Depends on psa_pkg and polygon_solid_angle.
`timescale 1ns / 100ps

module tb_polygon_solid_angle;
  import psa_pkg::*;

  localparam int unsigned CB = 24;
  localparam int unsigned AB = 32;
  localparam int unsigned IN_W = ((6*CB+7)/8)*8;
  localparam int unsigned OUT_W = ((AB+7)/8)*8;
  localparam int unsigned LIMIT = 3000000;
  localparam longint CMAX = 64'sd8388607;
  localparam longint CMIN = -64'sd8388608;
  localparam longint PI_FIX = 64'sd52707179;

  typedef struct {
    logic [AB-1:0] angle;
    logic          too_few;
  } area_t;

  logic             clk_i;
  logic             rst_ni;
  logic [IN_W-1:0]  s_axis_tdata;
  logic             s_axis_tuser;
  logic             s_axis_tlast;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready;

  area_t     pending_areas[$];
  int        errors;
  int        cycles;
  bit        no_idle;
  longint    cordic_step_angle[CORDIC_STEPS];

  // Predictor state of the open polygon.
  longint    org_x, org_y, org_z;
  longint    last_x, last_y, last_z;
  longint    eye_x, eye_y, eye_z;
  longint    area_acc;
  int        nverts;

  polygon_solid_angle #(.COORD_BITS(CB), .ANGLE_BITS(AB)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Floor integer square root, bit by bit.
  function automatic longint unsigned root_floor(input longint unsigned q);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > q) b = b >> 2;
    while (b != 0) begin
      if (q >= res + b) begin
        q = q - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Normalized CORDIC atan2 in Q.24, with atan2(0,0) = 0.
  function automatic longint vector_angle(input logic signed [127:0] ny,
                                          input logic signed [127:0] nx);
    logic [127:0] my, mx, both;
    int len, sh;
    longint x, y, z, dx, dy;
    my = (ny < 0) ? -ny : ny;
    mx = (nx < 0) ? -nx : nx;
    both = my | mx;
    len = 0;
    for (int i = 0; i < 128; i++) if (both[i]) len = i + 1;
    if (len == 0) return 0;
    sh = len - NRM_W;
    if (sh > 0) begin
      y = longint'(my >> sh);
      x = longint'(mx >> sh);
    end else begin
      y = longint'(my << (-sh));
      x = longint'(mx << (-sh));
    end
    if (ny < 0) y = -y;
    if (nx < 0) x = -x;
    if (y == 0) return (x < 0) ? PI_FIX : 0;
    z = 0;
    if (x < 0) begin
      z = (y > 0) ? PI_FIX : -PI_FIX;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += cordic_step_angle[i];
      end else begin
        x -= dx; y += dy; z -= cordic_step_angle[i];
      end
    end
    return z;
  endfunction

  // Solid angle of the fan triangle (first, previous, current).
  function automatic longint fan_triangle_angle(input longint cx, input longint cy,
                                                input longint cz);
    longint d[3][3];
    longint v[3][3];
    longint r[3];
    longint cr0, cr1, cr2, d12, d23, d31;
    longint unsigned q;
    logic signed [127:0] num, den;
    v[0][0] = org_x;  v[0][1] = org_y;  v[0][2] = org_z;
    v[1][0] = last_x; v[1][1] = last_y; v[1][2] = last_z;
    v[2][0] = cx;     v[2][1] = cy;     v[2][2] = cz;
    for (int k = 0; k < 3; k++) begin
      d[k][0] = v[k][0] - eye_x;
      d[k][1] = v[k][1] - eye_y;
      d[k][2] = v[k][2] - eye_z;
      q = d[k][0]*d[k][0] + d[k][1]*d[k][1] + d[k][2]*d[k][2];
      r[k] = longint'(root_floor(q));
    end
    cr0 = d[1][1]*d[2][2] - d[1][2]*d[2][1];
    cr1 = d[1][2]*d[2][0] - d[1][0]*d[2][2];
    cr2 = d[1][0]*d[2][1] - d[1][1]*d[2][0];
    num = 128'(signed'(d[0][0])) * 128'(signed'(cr0))
        + 128'(signed'(d[0][1])) * 128'(signed'(cr1))
        + 128'(signed'(d[0][2])) * 128'(signed'(cr2));
    d12 = d[0][0]*d[1][0] + d[0][1]*d[1][1] + d[0][2]*d[1][2];
    d23 = d[1][0]*d[2][0] + d[1][1]*d[2][1] + d[1][2]*d[2][2];
    d31 = d[2][0]*d[0][0] + d[2][1]*d[0][1] + d[2][2]*d[0][2];
    den = 128'(signed'(r[0]*r[1])) * 128'(signed'(r[2]))
        + 128'(signed'(d12)) * 128'(signed'(r[2]))
        + 128'(signed'(d23)) * 128'(signed'(r[0]))
        + 128'(signed'(d31)) * 128'(signed'(r[1]));
    return -2 * vector_angle(num, den);
  endfunction

  // Advance the predictor by one accepted vertex; queue the area on a closing one.
  task automatic predict_vertex(input longint vx, input longint vy, input longint vz,
                                input longint px, input longint py, input longint pz,
                                input bit opens, input bit closes);
    longint s;
    area_t a;
    if (opens || nverts == 0) begin
      org_x = vx; org_y = vy; org_z = vz;
      eye_x = px; eye_y = py; eye_z = pz;
      area_acc = 0;
      nverts = 1;
    end else if (nverts == 1) begin
      last_x = vx; last_y = vy; last_z = vz;
      nverts = 2;
    end else begin
      s = area_acc + fan_triangle_angle(vx, vy, vz);
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      else if (s < -64'sd2147483648) s = -64'sd2147483648;
      area_acc = s;
      last_x = vx; last_y = vy; last_z = vz;
      nverts = 3;
    end
    if (closes) begin
      a.too_few = (nverts < 3);
      a.angle = (nverts < 3) ? '0 : AB'(area_acc);
      pending_areas.push_back(a);
      nverts = 0;
    end
  endtask

  // Send one vertex transaction; entered and left at a falling edge.
  task automatic send_vertex(input longint vx, input longint vy, input longint vz,
                             input longint px, input longint py, input longint pz,
                             input bit opens, input bit closes);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {CB'(pz), CB'(py), CB'(px), CB'(vz), CB'(vy), CB'(vx)};
    s_axis_tuser  <= opens;
    s_axis_tlast  <= closes;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_vertex(vx, vy, vz, px, py, pz, opens, closes);
    @(negedge clk_i);
  endtask

  function automatic longint rand_coord();
    return longint'(signed'(CB'($urandom)));
  endfunction

  // Coordinate that is either full range or small around zero.
  function automatic longint rand_mixed();
    if ($urandom_range(0, 2) == 0) return rand_coord();
    return longint'($urandom_range(0, 600000)) - 300000;
  endfunction

  task automatic test_short_polygons();
    send_vertex(100, 200, 300, 0, 0, 0, 1, 1);
    send_vertex(65536, 0, 0, 0, 0, 0, 1, 0);
    send_vertex(0, 65536, 0, 0, 0, 0, 0, 1);
  endtask

  task automatic test_basic_shapes();
    // Unit triangle seen from above, then a square.
    send_vertex(65536, 0, 0, 0, 0, 65536, 1, 0);
    send_vertex(0, 65536, 0, 7, 7, 7, 0, 0);
    send_vertex(0, 0, 0, 7, 7, 7, 0, 1);
    send_vertex(65536, 65536, 0, 0, 0, -65536, 1, 0);
    send_vertex(-65536, 65536, 0, 0, 0, 0, 0, 0);
    send_vertex(-65536, -65536, 0, 0, 0, 0, 0, 0);
    send_vertex(65536, -65536, 0, 0, 0, 0, 0, 1);
  endtask

  task automatic test_extremes();
    send_vertex(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 1, 0);
    send_vertex(CMIN, CMAX, CMIN, CMAX, CMAX, CMAX, 0, 0);
    send_vertex(CMAX, CMIN, CMIN, 0, 0, 0, 0, 1);
    send_vertex(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1, 0);
    send_vertex(CMAX, CMIN, CMAX, 0, 0, 0, 0, 0);
    send_vertex(CMIN, CMAX, CMAX, 0, 0, 0, 0, 1);
  endtask

  task automatic test_degenerate();
    // All vertices on the point: both atan2 operands are zero.
    send_vertex(1000, -1000, 5, 1000, -1000, 5, 1, 0);
    send_vertex(1000, -1000, 5, 0, 0, 0, 0, 0);
    send_vertex(1000, -1000, 5, 0, 0, 0, 0, 1);
    // Point in the plane inside the triangle: zero numerator, negative denominator.
    send_vertex(65536, 0, 0, 0, 0, 0, 1, 0);
    send_vertex(0, 65536, 0, 0, 0, 0, 0, 0);
    send_vertex(-65536, -65536, 0, 0, 0, 0, 0, 1);
  endtask

  task automatic test_orphan_and_restart();
    // Vertices without an open polygon start one; a mid-polygon first drops it.
    send_vertex(30000, 0, 0, 0, 0, 9000, 0, 0);
    send_vertex(0, 30000, 0, 0, 0, 0, 0, 0);
    send_vertex(40000, 0, 0, 0, 0, -9000, 1, 0);
    send_vertex(0, 40000, 0, 0, 0, 0, 0, 0);
    send_vertex(-40000, -40000, 0, 0, 0, 0, 0, 1);
  endtask

  // A square wound many times around a point just above it drives the sum to both rails.
  task automatic test_saturation();
    longint sx[4];
    longint sy[4];
    int idx;
    sx = '{65536, 0, -65536, 0};
    sy = '{0, 65536, 0, -65536};
    for (int dir = 0; dir < 2; dir++) begin
      for (int k = 0; k <= 96; k++) begin
        idx = (dir == 0) ? (k % 4) : ((4 - (k % 4)) % 4);
        send_vertex(sx[idx], sy[idx], 0, 0, 0, 1, k == 0, k == 96);
      end
    end
  endtask

  task automatic test_random(input int n_items);
    int sent, nv;
    bit closes;
    sent = 0;
    while (sent < n_items) begin
      no_idle = ($urandom_range(0, 7) == 0);
      nv = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
      for (int k = 0; k < nv; k++) begin
        closes = (k == nv - 1) && ($urandom_range(0, 9) != 0);
        send_vertex(rand_mixed(), rand_mixed(), rand_mixed(),
                    rand_mixed(), rand_mixed(), rand_mixed(),
                    (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0),
                    closes);
        sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  // Result side: random stall before each transaction.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  // Compare each result transaction with the oldest queued area.
  always @(posedge clk_i) begin
    area_t exp_a;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_areas.size() == 0) begin
        $display("%0t: unexpected result angle=%h flag=%b", $time,
                 m_axis_tdata[AB-1:0], m_axis_tuser);
        errors++;
      end else begin
        exp_a = pending_areas.pop_front();
        if (m_axis_tdata[AB-1:0] !== exp_a.angle) begin
          $display("%0t: solid_angle expected %h actual %h", $time, exp_a.angle,
                   m_axis_tdata[AB-1:0]);
          errors++;
        end
        if (m_axis_tuser !== exp_a.too_few) begin
          $display("%0t: too_few_vertices expected %b actual %b", $time,
                   exp_a.too_few, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_polygon_solid_angle: errors");
      $finish;
    end
  end

  initial begin
    int tail;
    cordic_step_angle = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
                          131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
                          128, 64, 32, 16, 8, 4, 2, 1};
    errors = 0;
    cycles = 0;
    no_idle = 1'b0;
    org_x = 0; org_y = 0; org_z = 0;
    last_x = 0; last_y = 0; last_z = 0;
    eye_x = 0; eye_y = 0; eye_z = 0;
    area_acc = 0;
    nverts = 0;
    rst_ni = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    s_axis_tlast = 1'b0;
    s_axis_tvalid = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_short_polygons();
    test_basic_shapes();
    test_extremes();
    test_degenerate();
    test_orphan_and_restart();
    test_saturation();
    test_random(1200);

    s_axis_tvalid <= 1'b0;
    while (pending_areas.size() != 0) @(posedge clk_i);
    tail = 0;
    while (tail < 400) begin
      @(posedge clk_i);
      tail++;
    end
    if (errors == 0) begin
      $display("tb_polygon_solid_angle: clean");
    end else begin
      $display("tb_polygon_solid_angle: errors");
    end
    $finish;
  end

endmodule
